// ===== rtl/dll_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_pkg
// Shared command codes, controller state and control bundle for the
// doubly linked list engine.
// ----------------------------------------------------------------------------
package dll_pkg;

    typedef enum logic [4:0] {
        CMD_CLEAR      = 5'd0,
        CMD_INS_FIRST  = 5'd1,
        CMD_INS_LAST   = 5'd2,
        CMD_FIRST      = 5'd3,
        CMD_LAST       = 5'd4,
        CMD_RD_FIRST   = 5'd5,
        CMD_RD_LAST    = 5'd6,
        CMD_DEL_FIRST  = 5'd7,
        CMD_DEL_LAST   = 5'd8,
        CMD_DEL_AFTER  = 5'd9,
        CMD_DEL_BEFORE = 5'd10,
        CMD_INS_AFTER  = 5'd11,
        CMD_INS_BEFORE = 5'd12,
        CMD_RD_CURSOR  = 5'd13,
        CMD_WR_CURSOR  = 5'd14,
        CMD_NEXT       = 5'd15,
        CMD_PREV       = 5'd16,
        CMD_ACTIVE     = 5'd17
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD2  = 4'b0010,
        ST_WR1  = 4'b0100,
        ST_WR2  = 4'b1000
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd2;
        logic wr1;
        logic wr2;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/dll_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/dll_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_ctrl
// Command sequencer: accept, second read, two write phases.
// ----------------------------------------------------------------------------
module dll_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output dll_pkg::ctrl_t      ctrl
);

    dll_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dll_pkg::ST_IDLE: if (start) state_next = dll_pkg::ST_RD2;
            dll_pkg::ST_RD2:  state_next = dll_pkg::ST_WR1;
            dll_pkg::ST_WR1:  state_next = dll_pkg::ST_WR2;
            dll_pkg::ST_WR2:  state_next = dll_pkg::ST_IDLE;
            default:          state_next = dll_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dll_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != dll_pkg::ST_IDLE);
    assign ctrl.accept = start && (state_reg == dll_pkg::ST_IDLE);
    assign ctrl.rd2    = (state_reg == dll_pkg::ST_RD2);
    assign ctrl.wr1    = (state_reg == dll_pkg::ST_WR1);
    assign ctrl.wr2    = (state_reg == dll_pkg::ST_WR2);

endmodule
`default_nettype wire

// ===== rtl/dll_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_datapath
// List pointers, node memories and per-command link updates.
// ----------------------------------------------------------------------------
module dll_datapath #(
    parameter int NODE_COUNT = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dll_pkg::ctrl_t     ctrl,
    input  wire logic [4:0]         command,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic signed [31:0]      read_value,
    output logic                    error,
    output logic                    cursor_active
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int PW = $clog2(NODE_COUNT + 1);
    localparam logic [PW-1:0] NONE = PW'(NODE_COUNT);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] free_reg, free_next;
    logic [PW-1:0] hw_reg, hw_next;
    logic          done_reg;
    logic [31:0]   rd_reg, rd_next;
    logic          err_reg, err_next;

    dll_pkg::cmd_t cmd_reg;
    logic [31:0]   val_reg;
    logic [PW-1:0] d1n_reg, d1p_reg;
    logic [31:0]   d1v_reg;
    logic [PW-1:0] a_reg, b_reg, n_reg, nf_reg;
    logic          full_reg;

    logic [IW-1:0] raddr;
    logic [31:0]   val_q;
    logic [PW-1:0] next_q, prev_q;
    logic          vwe, nwe, pwe;
    logic [IW-1:0] vwa, nwa, pwa;
    logic [31:0]   vwd;
    logic [PW-1:0] nwd, pwd;

    logic [PW-1:0] a_c, b_c, n_c, nf_c;
    logic          full_c, free_ok, head_ok, tail_ok, cur_ok;
    logic          a_ok, b_ok;

    dll_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_val_ram (
        .clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(raddr), .rdata(val_q)
    );
    dll_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_next_ram (
        .clk(clk), .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(raddr), .rdata(next_q)
    );
    dll_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_prev_ram (
        .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(raddr), .rdata(prev_q)
    );

    assign free_ok = free_reg < NONE;
    assign head_ok = head_reg < NONE;
    assign tail_ok = tail_reg < NONE;
    assign cur_ok  = cur_reg < NONE;

    // read address: first read at accept, second read in the following cycle
    always_comb
    begin
        raddr = cur_reg[IW-1:0];
        if (ctrl.accept)
        begin
            case (dll_pkg::cmd_t'(command))
                dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST,
                dll_pkg::CMD_INS_AFTER, dll_pkg::CMD_INS_BEFORE:
                    raddr = free_reg[IW-1:0];
                dll_pkg::CMD_DEL_FIRST, dll_pkg::CMD_RD_FIRST:
                    raddr = head_reg[IW-1:0];
                dll_pkg::CMD_DEL_LAST, dll_pkg::CMD_RD_LAST:
                    raddr = tail_reg[IW-1:0];
                default:
                    raddr = cur_reg[IW-1:0];
            endcase
        end
        else
        begin
            case (cmd_reg)
                dll_pkg::CMD_DEL_AFTER:  raddr = next_q[IW-1:0];
                dll_pkg::CMD_DEL_BEFORE: raddr = prev_q[IW-1:0];
                default:                 raddr = cur_reg[IW-1:0];
            endcase
        end
    end

    // node allocation and neighbor links, valid in the first write phase
    always_comb
    begin
        full_c = !free_ok && !(hw_reg < NONE);
        n_c    = free_ok ? free_reg : hw_reg;
        nf_c   = free_ok ? d1n_reg : free_reg;
        a_c    = NONE;
        b_c    = NONE;
        case (cmd_reg)
            dll_pkg::CMD_DEL_FIRST:  a_c = d1n_reg;
            dll_pkg::CMD_DEL_LAST:   a_c = d1p_reg;
            dll_pkg::CMD_DEL_AFTER:
            begin
                a_c = d1n_reg;
                b_c = next_q;
            end
            dll_pkg::CMD_DEL_BEFORE:
            begin
                a_c = d1p_reg;
                b_c = prev_q;
            end
            dll_pkg::CMD_INS_AFTER:  a_c = next_q;
            dll_pkg::CMD_INS_BEFORE: a_c = prev_q;
            default:                 a_c = NONE;
        endcase
    end

    assign a_ok = (ctrl.wr1 ? a_c : a_reg) < NONE;
    assign b_ok = b_c < NONE;

    // memory writes
    always_comb
    begin
        vwe = 1'b0; vwa = n_c[IW-1:0]; vwd = val_reg;
        nwe = 1'b0; nwa = n_c[IW-1:0]; nwd = NONE;
        pwe = 1'b0; pwa = n_c[IW-1:0]; pwd = NONE;
        if (ctrl.wr1)
        begin
            case (cmd_reg)
                dll_pkg::CMD_INS_FIRST:
                    if (!full_c)
                    begin
                        vwe = 1'b1;
                        pwe = 1'b1;
                        nwe = 1'b1; nwd = head_reg;
                    end
                dll_pkg::CMD_INS_LAST:
                    if (!full_c)
                    begin
                        vwe = 1'b1;
                        nwe = 1'b1;
                        pwe = 1'b1; pwd = tail_reg;
                    end
                dll_pkg::CMD_DEL_FIRST:
                    if (head_ok)
                    begin
                        nwe = 1'b1; nwa = head_reg[IW-1:0]; nwd = free_reg;
                        pwe = a_ok; pwa = a_c[IW-1:0];
                    end
                dll_pkg::CMD_DEL_LAST:
                    if (tail_ok)
                    begin
                        nwe = 1'b1; nwa = tail_reg[IW-1:0]; nwd = free_reg;
                    end
                dll_pkg::CMD_DEL_AFTER:
                    if (cur_ok && cur_reg != tail_reg)
                    begin
                        nwe = 1'b1; nwa = cur_reg[IW-1:0]; nwd = b_c;
                        pwe = b_ok; pwa = b_c[IW-1:0]; pwd = cur_reg;
                    end
                dll_pkg::CMD_DEL_BEFORE:
                    if (cur_ok && cur_reg != head_reg)
                    begin
                        pwe = 1'b1; pwa = cur_reg[IW-1:0]; pwd = b_c;
                        nwe = b_ok; nwa = b_c[IW-1:0]; nwd = cur_reg;
                    end
                dll_pkg::CMD_INS_AFTER:
                    if (cur_ok && !full_c)
                    begin
                        vwe = 1'b1;
                        pwe = 1'b1; pwd = cur_reg;
                        nwe = 1'b1; nwd = a_c;
                    end
                dll_pkg::CMD_INS_BEFORE:
                    if (cur_ok && !full_c)
                    begin
                        vwe = 1'b1;
                        nwe = 1'b1; nwd = cur_reg;
                        pwe = 1'b1; pwd = a_c;
                    end
                dll_pkg::CMD_WR_CURSOR:
                    if (cur_ok)
                    begin
                        vwe = 1'b1; vwa = cur_reg[IW-1:0];
                    end
                default:
                    vwe = 1'b0;
            endcase
        end
        else if (ctrl.wr2)
        begin
            case (cmd_reg)
                dll_pkg::CMD_INS_FIRST:
                    if (!full_reg && head_ok)
                    begin
                        pwe = 1'b1; pwa = head_reg[IW-1:0]; pwd = n_reg;
                    end
                dll_pkg::CMD_INS_LAST:
                    if (!full_reg && tail_ok)
                    begin
                        nwe = 1'b1; nwa = tail_reg[IW-1:0]; nwd = n_reg;
                    end
                dll_pkg::CMD_DEL_LAST:
                    if (tail_ok && a_ok)
                    begin
                        nwe = 1'b1; nwa = a_reg[IW-1:0];
                    end
                dll_pkg::CMD_DEL_AFTER:
                    if (cur_ok && cur_reg != tail_reg && a_ok)
                    begin
                        nwe = 1'b1; nwa = a_reg[IW-1:0]; nwd = free_reg;
                    end
                dll_pkg::CMD_DEL_BEFORE:
                    if (cur_ok && cur_reg != head_reg && a_ok)
                    begin
                        nwe = 1'b1; nwa = a_reg[IW-1:0]; nwd = free_reg;
                    end
                dll_pkg::CMD_INS_AFTER:
                    if (cur_ok && !full_reg)
                    begin
                        pwe = a_ok; pwa = a_reg[IW-1:0]; pwd = n_reg;
                        nwe = 1'b1; nwa = cur_reg[IW-1:0]; nwd = n_reg;
                    end
                dll_pkg::CMD_INS_BEFORE:
                    if (cur_ok && !full_reg)
                    begin
                        nwe = a_ok; nwa = a_reg[IW-1:0]; nwd = n_reg;
                        pwe = 1'b1; pwa = cur_reg[IW-1:0]; pwd = n_reg;
                    end
                default:
                    nwe = 1'b0;
            endcase
        end
    end

    // pointer commit and result, in the second write phase
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cur_next  = cur_reg;
        free_next = free_reg;
        hw_next   = hw_reg;
        rd_next   = 32'd0;
        err_next  = 1'b0;
        case (cmd_reg)
            dll_pkg::CMD_CLEAR:
            begin
                head_next = NONE;
                tail_next = NONE;
                cur_next  = NONE;
                free_next = NONE;
                hw_next   = '0;
            end
            dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST:
                if (full_reg)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    free_next = nf_reg;
                    if (!free_ok) hw_next = hw_reg + 1'b1;
                    if (cmd_reg == dll_pkg::CMD_INS_FIRST)
                    begin
                        head_next = n_reg;
                        if (!head_ok) tail_next = n_reg;
                    end
                    else
                    begin
                        tail_next = n_reg;
                        if (!tail_ok) head_next = n_reg;
                    end
                end
            dll_pkg::CMD_FIRST: cur_next = head_reg;
            dll_pkg::CMD_LAST:  cur_next = tail_reg;
            dll_pkg::CMD_RD_FIRST:
                if (!head_ok) err_next = 1'b1; else rd_next = d1v_reg;
            dll_pkg::CMD_RD_LAST:
                if (!tail_ok) err_next = 1'b1; else rd_next = d1v_reg;
            dll_pkg::CMD_RD_CURSOR:
                if (!cur_ok) err_next = 1'b1; else rd_next = d1v_reg;
            dll_pkg::CMD_DEL_FIRST:
                if (head_ok)
                begin
                    if (cur_reg == head_reg) cur_next = NONE;
                    head_next = a_reg;
                    if (!a_ok) tail_next = NONE;
                    free_next = head_reg;
                end
            dll_pkg::CMD_DEL_LAST:
                if (tail_ok)
                begin
                    if (cur_reg == tail_reg) cur_next = NONE;
                    tail_next = a_reg;
                    if (!a_ok) head_next = NONE;
                    free_next = tail_reg;
                end
            dll_pkg::CMD_DEL_AFTER:
                if (cur_ok && cur_reg != tail_reg)
                begin
                    if (!(b_reg < NONE)) tail_next = cur_reg;
                    if (a_ok) free_next = a_reg;
                end
            dll_pkg::CMD_DEL_BEFORE:
                if (cur_ok && cur_reg != head_reg)
                begin
                    if (!(b_reg < NONE)) head_next = cur_reg;
                    if (a_ok) free_next = a_reg;
                end
            dll_pkg::CMD_INS_AFTER, dll_pkg::CMD_INS_BEFORE:
                if (cur_ok)
                begin
                    if (full_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        free_next = nf_reg;
                        if (!free_ok) hw_next = hw_reg + 1'b1;
                        if (!a_ok)
                        begin
                            if (cmd_reg == dll_pkg::CMD_INS_AFTER) tail_next = n_reg;
                            else head_next = n_reg;
                        end
                    end
                end
            dll_pkg::CMD_NEXT: if (cur_ok) cur_next = d1n_reg;
            dll_pkg::CMD_PREV: if (cur_ok) cur_next = d1p_reg;
            default: err_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NONE;
            tail_reg <= NONE;
            cur_reg  <= NONE;
            free_reg <= NONE;
            hw_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.wr2;
            if (ctrl.wr2)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cur_reg  <= cur_next;
                free_reg <= free_next;
                hw_reg   <= hw_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg <= dll_pkg::cmd_t'(command);
            val_reg <= value;
        end
        if (ctrl.rd2)
        begin
            d1n_reg <= next_q;
            d1p_reg <= prev_q;
            d1v_reg <= val_q;
        end
        if (ctrl.wr1)
        begin
            a_reg    <= a_c;
            b_reg    <= b_c;
            n_reg    <= n_c;
            nf_reg   <= nf_c;
            full_reg <= full_c;
        end
        if (ctrl.wr2)
        begin
            rd_reg  <= rd_next;
            err_reg <= err_next;
        end
    end

    assign done          = done_reg;
    assign read_value    = rd_reg;
    assign error         = err_reg;
    assign cursor_active = cur_reg < NONE;

endmodule
`default_nettype wire

// ===== rtl/doubly_linked_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Doubly linked list of 32-bit values in a fixed node pool, with a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, value) is taken at a rising edge with start high and
//   busy low. busy stays high after that edge while the engine steps
//   through the RD2, WR1 and WR2 states. The result (read_value, error,
//   cursor_active) is shown for one cycle with done high; done is
//   registered from the WR2 state, and the receiver cannot stall, so the
//   result must be captured in that cycle.
//   Each item takes one read of the node memories at acceptance, a second
//   dependent read, then two write phases since a command may update up
//   to two links held in the same memory; no new item is taken while busy.
//   A new item may be started in the same cycle that done is high.
//   Reset clears the head, tail, cursor and free list pointers and the
//   allocation mark; the node memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
    parameter int NODE_COUNT = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [4:0]         command,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic signed [31:0]      read_value,
    output logic                    error,
    output logic                    cursor_active
);

    dll_pkg::ctrl_t ctrl;

    dll_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    dll_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .command       (command),
        .value         (value),
        .done          (done),
        .read_value    (read_value),
        .error         (error),
        .cursor_active (cursor_active)
    );

endmodule
`default_nettype wire
